>>> hdl/chme_pkg.sv
// chained hash map engine: shared types and fixed field widths
// no dependencies; used by chme_bucket_hash and chained_hash_map_engine_unit
`timescale 1ns / 1ps

package chme_pkg;

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 10;

    // stored_count saturates here
    localparam int COUNT_MAX = 1023;

    // operation codes
    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

endpackage

>>> hdl/chme_bucket_hash.sv
// chained hash map engine: bucket index from a 64-bit key
// xor-folds the key into IDX_W-bit chunks, then reduces below NUM_BUCKETS
// depends on chme_pkg
`timescale 1ns / 1ps

module chme_bucket_hash #(
    parameter int NUM_BUCKETS = 64,
    parameter int IDX_W       = 6
) (
    input  logic [chme_pkg::KEY_W-1:0] key,
    output logic [IDX_W-1:0]           bucket
);

    localparam int CHUNKS = (chme_pkg::KEY_W + IDX_W - 1) / IDX_W;
    localparam logic [IDX_W:0] NB = (IDX_W + 1)'(NUM_BUCKETS);

    logic [IDX_W-1:0] folded;
    logic [IDX_W:0]   folded_ext;

    // fold: each index bit is the xor of the matching bit of every chunk
    always_comb
    begin
        folded = '0;
        for (int j = 0; j < IDX_W; j++)
        begin
            for (int c = 0; c < CHUNKS; c++)
            begin
                if (c * IDX_W + j < chme_pkg::KEY_W)
                begin
                    folded[j] = folded[j] ^ key[c * IDX_W + j];
                end
            end
        end
    end

    // folded value stays below twice the bucket count: one compare and subtract
    always_comb
    begin
        folded_ext = {1'b0, folded};
        if (folded_ext >= NB)
        begin
            bucket = IDX_W'(folded_ext - NB);
        end
        else
        begin
            bucket = folded;
        end
    end

endmodule

>>> hdl/chained_hash_map_engine_unit.sv
// chained hash map engine: top level, sequencer, entry and fill memories
// depends on chme_pkg and chme_bucket_hash
`timescale 1ns / 1ps

// Key-value table of 64-bit keys and signed 32-bit values in NUM_BUCKETS
// buckets of BUCKET_DEPTH entries. One request beat (operation, key,
// new_value) on in_valid/in_ready gives exactly one result beat (found,
// read_value, bucket_full, stored_count) on out_valid/out_ready.
// One key comparator is shared: the bucket's entries are read one per
// memory access and compared in turn, each in a look and a compare state.
// A remove that hits moves the bucket's last entry into the freed slot in
// an extra move state, and clear sweeps the fill memory to zero the fill
// counts of all buckets.
// One request is in flight at a time: in_ready is high only while idle,
// and the result register holds its beat while out_ready is low; the next
// request is taken the cycle after the result beat.
// After reset the fill memory is zeroed by a pass over all NUM_BUCKETS
// buckets, during which in_ready stays low.

module chained_hash_map_engine_unit #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [chme_pkg::KEY_W-1:0]         key,
    input  logic signed [chme_pkg::VAL_W-1:0]  new_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic signed [chme_pkg::VAL_W-1:0]  read_value,
    output logic                               bucket_full,
    output logic [chme_pkg::COUNT_W-1:0]       stored_count
);

    localparam int TABLE_SIZE = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int IDX_W      = $clog2(NUM_BUCKETS);
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int FILL_W     = $clog2(BUCKET_DEPTH + 1);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int SAT_W      = (CNT_W > chme_pkg::COUNT_W) ? CNT_W : chme_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_FILL,
        S_LOOK,
        S_CMP,
        S_ACT,
        S_MOVE,
        S_OUT
    } state_t;

    // memories
    logic [chme_pkg::KEY_W-1:0] key_mem  [TABLE_SIZE];
    logic [chme_pkg::VAL_W-1:0] val_mem  [TABLE_SIZE];
    logic [FILL_W-1:0]          fill_mem [NUM_BUCKETS];

    state_t                     state_reg;
    chme_pkg::op_t              op_reg;
    logic [chme_pkg::KEY_W-1:0] key_reg;
    logic [chme_pkg::VAL_W-1:0] nv_reg;
    logic [IDX_W-1:0]           bucket_reg;
    logic [ADDR_W-1:0]          base_reg;
    logic [FILL_W-1:0]          slot_reg;
    logic [FILL_W-1:0]          hit_reg;
    logic [IDX_W-1:0]           sweep_reg;
    logic                       clr_reg;
    logic [CNT_W-1:0]           total_reg;
    logic                       found_reg;
    logic [chme_pkg::VAL_W-1:0] rd_reg;
    logic                       full_reg;

    // registered memory read data
    logic [chme_pkg::KEY_W-1:0] key_rd_reg;
    logic [chme_pkg::VAL_W-1:0] val_rd_reg;
    logic [FILL_W-1:0]          fill_rd_reg;

    logic [IDX_W-1:0]           hash_bucket;
    logic [ADDR_W-1:0]          slot_addr;
    logic [ADDR_W-1:0]          hit_addr;
    logic [ADDR_W-1:0]          last_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       key_we;
    logic                       val_we;
    logic [chme_pkg::KEY_W-1:0] wr_key;
    logic [chme_pkg::VAL_W-1:0] wr_val;
    logic                       fill_we;
    logic [IDX_W-1:0]           fill_wa;
    logic [FILL_W-1:0]          fill_wd;
    logic                       bucket_is_full;
    logic [SAT_W-1:0]           total_ext;

    chme_bucket_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .IDX_W       (IDX_W)
    ) u_hash (
        .key    (key),
        .bucket (hash_bucket)
    );

    // entry addresses inside the selected bucket
    assign slot_addr      = base_reg + ADDR_W'(slot_reg);
    assign hit_addr       = base_reg + ADDR_W'(hit_reg);
    assign last_addr      = base_reg + ADDR_W'(fill_rd_reg - FILL_W'(1));
    assign rd_addr        = (state_reg == S_ACT) ? last_addr : slot_addr;
    assign bucket_is_full = (fill_rd_reg >= FILL_W'(BUCKET_DEPTH));

    // memory write controls
    always_comb
    begin
        key_we  = 1'b0;
        val_we  = 1'b0;
        wr_addr = hit_addr;
        wr_key  = key_reg;
        wr_val  = nv_reg;
        fill_we = 1'b0;
        fill_wa = bucket_reg;
        fill_wd = fill_rd_reg;
        unique case (state_reg)
            S_ACT:
            begin
                if (op_reg == chme_pkg::OP_SET)
                begin
                    if (found_reg)
                    begin
                        val_we = 1'b1;
                    end
                    else if (!bucket_is_full)
                    begin
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        wr_addr = base_reg + ADDR_W'(fill_rd_reg);
                        fill_we = 1'b1;
                        fill_wd = fill_rd_reg + FILL_W'(1);
                    end
                end
            end
            S_MOVE:
            begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                wr_key  = key_rd_reg;
                wr_val  = val_rd_reg;
                fill_we = 1'b1;
                fill_wd = fill_rd_reg - FILL_W'(1);
            end
            S_SWEEP:
            begin
                fill_we = 1'b1;
                fill_wa = sweep_reg;
                fill_wd = '0;
            end
            default:
            begin
            end
        endcase
    end

    // entry memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    // bucket fill memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_wa] <= fill_wd;
        end
        fill_rd_reg <= fill_mem[bucket_reg];
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            clr_reg   <= 1'b0;
            total_reg <= '0;
            found_reg <= 1'b0;
            rd_reg    <= '0;
            full_reg  <= 1'b0;
            op_reg    <= chme_pkg::OP_GET;
        end
        else
        begin
            unique case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_reg == IDX_W'(NUM_BUCKETS - 1))
                    begin
                        sweep_reg <= '0;
                        state_reg <= clr_reg ? S_OUT : S_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + IDX_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= chme_pkg::op_t'(operation);
                        key_reg    <= key;
                        nv_reg     <= new_value;
                        bucket_reg <= hash_bucket;
                        state_reg  <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    base_reg  <= ADDR_W'(bucket_reg * BUCKET_DEPTH);
                    slot_reg  <= '0;
                    hit_reg   <= '0;
                    found_reg <= 1'b0;
                    clr_reg   <= 1'b0;
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    // fill count is valid from here on
                    if (slot_reg >= fill_rd_reg)
                    begin
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (key_rd_reg == key_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= slot_reg;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + FILL_W'(1);
                        state_reg <= S_LOOK;
                    end
                end
                S_ACT:
                begin
                    unique case (op_reg)
                        chme_pkg::OP_GET:
                        begin
                            rd_reg    <= found_reg ? val_rd_reg : '0;
                            full_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        chme_pkg::OP_SET:
                        begin
                            rd_reg    <= '0;
                            full_reg  <= !found_reg && bucket_is_full;
                            state_reg <= S_OUT;
                            if (!found_reg && !bucket_is_full)
                            begin
                                total_reg <= total_reg + CNT_W'(1);
                            end
                        end
                        chme_pkg::OP_REMOVE:
                        begin
                            // last entry is being read for the move
                            rd_reg    <= '0;
                            full_reg  <= 1'b0;
                            state_reg <= found_reg ? S_MOVE : S_OUT;
                        end
                        chme_pkg::OP_CLEAR:
                        begin
                            rd_reg    <= '0;
                            full_reg  <= 1'b0;
                            total_reg <= '0;
                            sweep_reg <= '0;
                            clr_reg   <= 1'b1;
                            state_reg <= S_SWEEP;
                        end
                    endcase
                end
                S_MOVE:
                begin
                    if (total_reg != '0)
                    begin
                        total_reg <= total_reg - CNT_W'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // handshake and result ports
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign found       = found_reg;
    assign read_value  = rd_reg;
    assign bucket_full = full_reg;

    // entry count, saturated to the port width
    assign total_ext = SAT_W'(total_reg);
    assign stored_count = (total_ext > SAT_W'(chme_pkg::COUNT_MAX))
                        ? chme_pkg::COUNT_W'(chme_pkg::COUNT_MAX)
                        : chme_pkg::COUNT_W'(total_ext);

endmodule
